@@ src/sbel_pkg.sv @@
// Shared constants, codes and interface structs of the encoding index loader.
package sbel_pkg;

  localparam int unsigned TABLE_ENTRIES = 256;
  localparam int unsigned ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CP_W          = 21;
  localparam int unsigned BYTE_W        = 8;
  localparam logic [CP_W-1:0] MAX_CODEPOINT = 21'h10FFFF;

  typedef enum logic [1:0] {
    CMD_PARSE = 2'd0,
    CMD_FWD   = 2'd1,
    CMD_REV   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_CONSUMED = 2'd0,
    STAT_STORED   = 2'd1,
    STAT_ERROR    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ERR_NONE        = 3'd0,
    ERR_LINE        = 3'd1,
    ERR_PRE_INDEX   = 3'd2,
    ERR_EMPTY_INDEX = 3'd3,
    ERR_PRE_CODE    = 3'd4,
    ERR_EMPTY_CODE  = 3'd5,
    ERR_OVERFLOW    = 3'd6
  } err_kind_e;

  // Parser view for the sequencer: pair to store and the error after this step.
  typedef struct packed {
    logic              store;
    logic [ADDR_W-1:0] idx;
    logic [CP_W-1:0]   cp;
    err_kind_e         err;
  } parse_res_t;

  // Scan request to the reverse list.
  typedef struct packed {
    logic              start;
    logic              append;
    logic [CP_W-1:0]   key;
    logic [BYTE_W-1:0] wr_byte;
  } rev_cmd_t;

  // Scan completion from the reverse list.
  typedef struct packed {
    logic              done;
    logic              hit;
    logic [BYTE_W-1:0] rd_byte;
  } rev_res_t;

endpackage

@@ src/sbel_parser.sv @@
// Line parser of the index text: phase, index and codepoint accumulators.
module sbel_parser (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_en_i,
  input  logic [7:0]               text_byte_i,
  output sbel_pkg::parse_res_t     res_o
);
  import sbel_pkg::*;

  typedef enum logic [6:0] {
    PH_LINE      = 7'b0000001,
    PH_SKIP      = 7'b0000010,
    PH_PRE_INDEX = 7'b0000100,
    PH_INDEX     = 7'b0001000,
    PH_PRE_CODE  = 7'b0010000,
    PH_CODE      = 7'b0100000,
    PH_ERR       = 7'b1000000
  } phase_e;

  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam int unsigned IDX_EXT_W = ADDR_W + 4;

  phase_e            phase_q, phase_d;
  err_kind_e         err_q, err_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [1:0]        idx_cnt_q, idx_cnt_d;
  logic [CP_W-1:0]   cp_q, cp_d;
  logic [2:0]        cp_cnt_q, cp_cnt_d;

  logic                 is_blank, is_dec, is_hex, is_lf, pre_code_skip;
  logic [3:0]           hex_val;
  logic [IDX_EXT_W-1:0] idx_ext, idx_next;
  logic [CP_W-1:0]      cp_next;
  logic                 idx_ovf, cp_ovf, store;

  always_comb begin
    is_blank = (text_byte_i == CH_SPACE) || (text_byte_i == CH_TAB);
    is_dec   = (text_byte_i >= CH_ZERO) && (text_byte_i <= 8'h39);
    is_lf    = (text_byte_i == CH_LF);
    pre_code_skip = is_blank || (text_byte_i == CH_ZERO);
    is_hex   = 1'b1;
    hex_val  = text_byte_i[3:0];
    if (is_dec) begin
      hex_val = text_byte_i[3:0];
    end else if ((text_byte_i >= 8'h61 && text_byte_i <= 8'h66) ||
                 (text_byte_i >= 8'h41 && text_byte_i <= 8'h46)) begin
      // Letters a-f and A-F share their low nibble 1..6.
      hex_val = text_byte_i[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  // Decimal step: index * 10 + digit, and hex step: codepoint * 16 + digit.
  assign idx_ext  = IDX_EXT_W'(idx_q);
  assign idx_next = (idx_ext << 3) + (idx_ext << 1) + IDX_EXT_W'(text_byte_i[3:0]);
  assign idx_ovf  = idx_next >= IDX_EXT_W'(TABLE_ENTRIES);
  assign cp_next  = {cp_q[CP_W-5:0], hex_val};
  assign cp_ovf   = (cp_q > (MAX_CODEPOINT >> 4)) || (cp_next > MAX_CODEPOINT);

  always_comb begin
    phase_d   = phase_q;
    err_d     = err_q;
    idx_d     = idx_q;
    idx_cnt_d = idx_cnt_q;
    cp_d      = cp_q;
    cp_cnt_d  = cp_cnt_q;
    store     = 1'b0;
    if (step_en_i) begin
      unique case (phase_q)
        PH_LINE: begin
          if (text_byte_i == CH_HASH) begin
            phase_d = PH_SKIP;
          end else if (is_lf) begin
            phase_d = PH_LINE;
          end else if (is_blank) begin
            phase_d = PH_PRE_INDEX;
          end else if (is_dec) begin
            phase_d   = PH_INDEX;
            idx_d     = ADDR_W'(text_byte_i[3:0]);
            idx_cnt_d = 2'd1;
          end else begin
            phase_d = PH_ERR;
            err_d   = ERR_LINE;
          end
        end
        PH_SKIP: begin
          if (is_lf) begin
            phase_d = PH_LINE;
          end
        end
        PH_PRE_INDEX: begin
          if (is_dec) begin
            phase_d   = PH_INDEX;
            idx_d     = ADDR_W'(text_byte_i[3:0]);
            idx_cnt_d = 2'd1;
          end else if (!is_blank) begin
            phase_d = PH_ERR;
            err_d   = ERR_PRE_INDEX;
          end
        end
        PH_INDEX: begin
          if (is_dec) begin
            if (idx_ovf) begin
              phase_d = PH_ERR;
              err_d   = ERR_OVERFLOW;
            end else begin
              idx_d = idx_next[ADDR_W-1:0];
              if (idx_cnt_q != 2'd3) begin
                idx_cnt_d = idx_cnt_q + 2'd1;
              end
            end
          end else if (idx_cnt_q == 2'd0) begin
            phase_d = PH_ERR;
            err_d   = ERR_EMPTY_INDEX;
          end else if (pre_code_skip) begin
            // The byte that ends the index is handled as a separator byte.
            phase_d = PH_PRE_CODE;
          end else if (text_byte_i == CH_X) begin
            phase_d  = PH_CODE;
            cp_d     = '0;
            cp_cnt_d = 3'd0;
          end else begin
            phase_d = PH_ERR;
            err_d   = ERR_PRE_CODE;
          end
        end
        PH_PRE_CODE: begin
          if (text_byte_i == CH_X) begin
            phase_d  = PH_CODE;
            cp_d     = '0;
            cp_cnt_d = 3'd0;
          end else if (!pre_code_skip) begin
            phase_d = PH_ERR;
            err_d   = ERR_PRE_CODE;
          end
        end
        PH_CODE: begin
          if (is_hex) begin
            if (cp_ovf) begin
              phase_d = PH_ERR;
              err_d   = ERR_OVERFLOW;
            end else begin
              cp_d = cp_next;
              if (cp_cnt_q != 3'd7) begin
                cp_cnt_d = cp_cnt_q + 3'd1;
              end
            end
          end else if (cp_cnt_q == 3'd0) begin
            phase_d = PH_ERR;
            err_d   = ERR_EMPTY_CODE;
          end else begin
            store   = 1'b1;
            phase_d = is_lf ? PH_LINE : PH_SKIP;
          end
        end
        PH_ERR: begin
          phase_d = PH_ERR;
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LINE;
      err_q     <= ERR_NONE;
      idx_q     <= '0;
      idx_cnt_q <= 2'd0;
      cp_q      <= '0;
      cp_cnt_q  <= 3'd0;
    end else begin
      phase_q   <= phase_d;
      err_q     <= err_d;
      idx_q     <= idx_d;
      idx_cnt_q <= idx_cnt_d;
      cp_q      <= cp_d;
      cp_cnt_q  <= cp_cnt_d;
    end
  end

  assign res_o.store = store;
  assign res_o.idx   = idx_q;
  assign res_o.cp    = cp_q;
  assign res_o.err   = err_d;

endmodule

@@ src/sbel_fwd_table.sv @@
// Forward table memory with per-entry valid bits so that reset clears it at once.
module sbel_fwd_table (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        wr_en_i,
  input  logic [sbel_pkg::ADDR_W-1:0] wr_addr_i,
  input  logic [sbel_pkg::CP_W-1:0]   wr_data_i,
  input  logic                        rd_en_i,
  input  logic [sbel_pkg::ADDR_W-1:0] rd_addr_i,
  output logic [sbel_pkg::CP_W-1:0]   rd_data_o
);
  import sbel_pkg::*;

  logic [CP_W-1:0]          mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [CP_W-1:0]          rd_data_q;
  logic                     rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= valid_q[rd_addr_i];
      end
    end
  end

  // An entry never written reads as zero.
  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

@@ src/sbel_rev_list.sv @@
// Reverse list memory with the shared scan comparator and append-on-miss.
module sbel_rev_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbel_pkg::rev_cmd_t cmd_i,
  output sbel_pkg::rev_res_t res_o
);
  import sbel_pkg::*;

  logic [CP_W-1:0]   codes [TABLE_ENTRIES];
  logic [BYTE_W-1:0] bytes_mem [TABLE_ENTRIES];

  logic              active_q, append_q, cmp_vld_q;
  logic [CP_W-1:0]   key_q;
  logic [BYTE_W-1:0] wr_byte_q;
  logic [CNT_W-1:0]  ptr_q, count_q;
  logic [CP_W-1:0]   rd_code_q;
  logic [BYTE_W-1:0] rd_byte_q;

  logic rd_en, match, miss, append_en;

  // One read per cycle; the comparator looks at the entry read the cycle before.
  assign rd_en     = active_q && !match && (ptr_q < count_q);
  assign match     = active_q && cmp_vld_q && (rd_code_q == key_q);
  assign miss      = active_q && !cmp_vld_q && (ptr_q == count_q);
  assign append_en = miss && append_q && (count_q < CNT_W'(TABLE_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (append_en) begin
      codes[count_q[ADDR_W-1:0]]     <= key_q;
      bytes_mem[count_q[ADDR_W-1:0]] <= wr_byte_q;
    end
    if (rd_en) begin
      rd_code_q <= codes[ptr_q[ADDR_W-1:0]];
      rd_byte_q <= bytes_mem[ptr_q[ADDR_W-1:0]];
    end
    if (cmd_i.start) begin
      key_q     <= cmd_i.key;
      wr_byte_q <= cmd_i.wr_byte;
      append_q  <= cmd_i.append;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      cmp_vld_q <= 1'b0;
      ptr_q     <= '0;
      count_q   <= '0;
    end else begin
      if (cmd_i.start) begin
        active_q  <= 1'b1;
        cmp_vld_q <= 1'b0;
        ptr_q     <= '0;
      end else if (match || miss) begin
        active_q  <= 1'b0;
        cmp_vld_q <= 1'b0;
      end else if (active_q) begin
        cmp_vld_q <= rd_en;
        if (rd_en) begin
          ptr_q <= ptr_q + CNT_W'(1);
        end
      end
      if (append_en) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  assign res_o.done    = match || miss;
  assign res_o.hit     = match;
  assign res_o.rd_byte = match ? rd_byte_q : '0;

endmodule

@@ src/single_byte_encoding_index_loader.sv @@
// Top level: command sequencer around the parser, forward table and reverse list.
// A text byte that completes no line, or a forward lookup, runs through the execute state and is then strobed out.
// A byte that completes a line, and a reverse lookup, scan the reverse list one
// entry per cycle through a single comparator; the list holds at most 256 entries.
// A new command transfers in the cycle its predecessor's result is strobed.
// Reset empties both tables at once through valid bits and a fill count.
module single_byte_encoding_index_loader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  text_byte_i,
  input  logic [7:0]  query_byte_i,
  input  logic [20:0] query_codepoint_i,
  output logic        busy,
  output logic        done,
  output logic [1:0]  parse_status_o,
  output logic [2:0]  error_kind_o,
  output logic [20:0] codepoint_out_o,
  output logic [7:0]  byte_out_o,
  output logic        found_o
);
  import sbel_pkg::*;

  // The sequencer is idle, executes one command, or waits on a reverse scan.
  typedef enum logic [2:0] {
    SEQ_IDLE = 3'b001,
    SEQ_EXEC = 3'b010,
    SEQ_SCAN = 3'b100
  } seq_state_e;

  seq_state_e state_q, state_d;

  // Command fields captured at the transfer.
  logic [1:0]        cmd_q;
  logic [7:0]        text_q;
  logic [CP_W-1:0]   qcp_q;
  logic              qry_ok_q;

  // Result registers and the one-cycle strobe.
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  err_kind_e         err_q, err_d;
  logic [CP_W-1:0]   cp_out_q, cp_out_d;
  logic [BYTE_W-1:0] byte_out_q, byte_out_d;
  logic              found_q, found_d;

  logic              accept, step_en, finish;
  parse_res_t        parse_res;
  rev_cmd_t          rev_cmd;
  rev_res_t          rev_res;
  logic [CP_W-1:0]   fwd_rd_data;

  assign accept = start && (state_q == SEQ_IDLE);

  sbel_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (step_en),
    .text_byte_i (text_q),
    .res_o       (parse_res)
  );

  // The forward read is launched at the transfer so its data is ready in the
  // execute cycle. The write of a completed line happens in the execute cycle.
  sbel_fwd_table u_fwd (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (step_en && parse_res.store),
    .wr_addr_i (parse_res.idx),
    .wr_data_i (parse_res.cp),
    .rd_en_i   (accept),
    .rd_addr_i (query_byte_i[ADDR_W-1:0]),
    .rd_data_o (fwd_rd_data)
  );

  sbel_rev_list u_rev (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (rev_cmd),
    .res_o  (rev_res)
  );

  always_comb begin
    state_d         = state_q;
    step_en         = 1'b0;
    finish          = 1'b0;
    rev_cmd.start   = 1'b0;
    rev_cmd.append  = 1'b0;
    rev_cmd.key     = qcp_q;
    rev_cmd.wr_byte = BYTE_W'(parse_res.idx);
    status_d        = STAT_CONSUMED;
    cp_out_d        = '0;
    byte_out_d      = '0;
    found_d         = 1'b0;

    unique case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          state_d = SEQ_EXEC;
        end
      end
      SEQ_EXEC: begin
        case (cmd_q)
          CMD_PARSE: begin
            step_en = 1'b1;
            if (parse_res.store) begin
              // A completed line still has to be checked against the list.
              rev_cmd.start  = 1'b1;
              rev_cmd.append = 1'b1;
              rev_cmd.key    = parse_res.cp;
              state_d        = SEQ_SCAN;
            end else begin
              finish = 1'b1;
            end
          end
          CMD_FWD: begin
            cp_out_d = qry_ok_q ? fwd_rd_data : '0;
            finish   = 1'b1;
          end
          CMD_REV: begin
            rev_cmd.start = 1'b1;
            state_d       = SEQ_SCAN;
          end
          default: begin
            finish = 1'b1;
          end
        endcase
      end
      SEQ_SCAN: begin
        if (rev_res.done) begin
          finish = 1'b1;
          if (cmd_q == CMD_PARSE) begin
            status_d = STAT_STORED;
          end else begin
            byte_out_d = rev_res.rd_byte;
            found_d    = rev_res.hit;
          end
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase

    if (finish) begin
      state_d = SEQ_IDLE;
    end
    // The error is sticky and reported with every result once latched.
    err_d = parse_res.err;
    if (parse_res.err != ERR_NONE) begin
      status_d = STAT_ERROR;
    end
    done_d = finish;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_i;
      text_q   <= text_byte_i;
      qcp_q    <= query_codepoint_i;
      qry_ok_q <= {1'b0, query_byte_i} < 9'(TABLE_ENTRIES);
    end
    if (finish) begin
      status_q   <= status_d;
      err_q      <= err_d;
      cp_out_q   <= cp_out_d;
      byte_out_q <= byte_out_d;
      found_q    <= found_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy            = (state_q != SEQ_IDLE);
  assign done            = done_q;
  assign parse_status_o  = status_q;
  assign error_kind_o    = err_q;
  assign codepoint_out_o = cp_out_q;
  assign byte_out_o      = byte_out_q;
  assign found_o         = found_q;

endmodule

@@ src/sbel_checker.sv @@
// Port-level checker of the loader and its bind to the top level.
module sbel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [1:0]  parse_status_o,
  input logic [2:0]  error_kind_o,
  input logic [7:0]  byte_out_o,
  input logic        found_o
);
  import sbel_pkg::*;

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("block not busy after a command transfer");

  a_done_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done)
    else $error("busy dropped without a result strobe");

  a_done_only_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !busy && $past(busy))
    else $error("result strobe without a finished command");

  a_status_matches_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> ((parse_status_o == STAT_ERROR) == (error_kind_o != ERR_NONE)))
    else $error("parse status and error kind disagree");

  a_miss_has_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && !found_o |-> byte_out_o == 8'd0)
    else $error("nonzero byte reported without a hit");

endmodule

bind single_byte_encoding_index_loader sbel_checker u_sbel_checker (.*);

@@ verif/tb.sv @@
// Self-checking testbench for the encoding index loader: feeds index text and lookups, predicts every reply.
module tb;
  import sbel_pkg::*;

  // Command code the block does not define; it must change nothing.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Characters that the index text grammar gives meaning to.
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_X       = 8'h78;

  // The slowest legal run is a few thousand transfers, each of which may wait on a full reverse scan.
  localparam int CYCLE_LIMIT = 2_000_000;
  // A store or reverse lookup scans at most 256 entries.
  localparam int DRAIN_CYCLES = 300;
  localparam int MAX_REPORTS = 50;

  // Where the text parser stands within the current line.
  typedef enum logic [2:0] {
    LINE_START,
    SKIP_LINE,
    BEFORE_INDEX,
    IN_INDEX,
    BEFORE_CODE,
    IN_CODE,
    HALTED
  } parse_phase_e;

  // One command waiting to be offered; a pause mark holds the feed until all replies are in.
  typedef struct {
    bit          pause_mark;
    logic [1:0]  op;
    logic [7:0]  text;
    logic [7:0]  qbyte;
    logic [20:0] qcode;
  } feed_item_t;

  // One reply of the block, as the ports carry it.
  typedef struct {
    status_e     status;
    err_kind_e   err;
    logic [20:0] code;
    logic [7:0]  bval;
    logic        hit;
  } reply_t;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        start             = 1'b0;
  logic [1:0]  cmd_i             = CMD_PARSE;
  logic [7:0]  text_byte_i       = '0;
  logic [7:0]  query_byte_i      = '0;
  logic [20:0] query_codepoint_i = '0;
  logic        busy;
  logic        done;
  logic [1:0]  parse_status_o;
  logic [2:0]  error_kind_o;
  logic [20:0] codepoint_out_o;
  logic [7:0]  byte_out_o;
  logic        found_o;

  single_byte_encoding_index_loader DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .cmd_i             (cmd_i),
    .text_byte_i       (text_byte_i),
    .query_byte_i      (query_byte_i),
    .query_codepoint_i (query_codepoint_i),
    .busy              (busy),
    .done              (done),
    .parse_status_o    (parse_status_o),
    .error_kind_o      (error_kind_o),
    .codepoint_out_o   (codepoint_out_o),
    .byte_out_o        (byte_out_o),
    .found_o           (found_o)
  );

  always #5 clk_i = ~clk_i;

  // Commands not yet offered, and replies owed by the block in transfer order.
  feed_item_t text_feed [$];
  reply_t     replies_owed [$];

  int mismatches  = 0;
  int sent_count  = 0;
  int cycle_count = 0;
  // Set at each rising edge when the offered command was taken by the block.
  bit xfer_now    = 1'b0;

  // Mirror of the loader's state, advanced once per accepted command.
  parse_phase_e phase       = LINE_START;
  err_kind_e    latched_err = ERR_NONE;
  logic [8:0]   idx_acc     = '0;
  logic [1:0]   idx_cnt     = '0;
  logic [20:0]  cp_acc      = '0;
  logic [2:0]   cp_cnt      = '0;
  logic [20:0]  fwd_map  [TABLE_ENTRIES];
  logic [20:0]  rev_code [TABLE_ENTRIES];
  logic [7:0]   rev_byte [TABLE_ENTRIES];
  int           rev_fill    = 0;

  initial begin
    foreach (fwd_map[i]) fwd_map[i] = '0;
  end

  function automatic bit is_blank(input logic [7:0] b);
    return b == CH_SPACE || b == CH_TAB;
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= CH_ZERO && b <= CH_NINE;
  endfunction

  // Value of a hex digit in either case, or -1 for any other byte.
  function automatic int hex_value(input logic [7:0] b);
    if (is_digit(b)) return int'(b - CH_ZERO);
    if (b >= CH_LOWER_A && b <= CH_LOWER_F) return int'(b - CH_LOWER_A) + 10;
    if (b >= CH_UPPER_A && b <= CH_UPPER_F) return int'(b - CH_UPPER_A) + 10;
    return -1;
  endfunction

  // Errors are sticky: nothing parses again for the rest of the run.
  function automatic void halt(input err_kind_e kind);
    phase       = HALTED;
    latched_err = kind;
  endfunction

  // The forward table always takes the new pair; the reverse list keeps the
  // first byte seen for a codepoint and stops growing once it is full.
  function automatic void store_pair();
    bit dup;
    dup = 1'b0;
    fwd_map[idx_acc[7:0]] = cp_acc;
    for (int i = 0; i < rev_fill; i++)
      if (rev_code[i] == cp_acc) dup = 1'b1;
    if (!dup && rev_fill < TABLE_ENTRIES) begin
      rev_code[rev_fill] = cp_acc;
      rev_byte[rev_fill] = idx_acc[7:0];
      rev_fill++;
    end
  endfunction

  // Advances the line parser by one byte; returns 1 when the byte completed a pair.
  // A byte that ends one field is handed straight on to the next field, hence the loop.
  function automatic bit parse_text_byte(input logic [7:0] b);
    int          nib;
    int          iv;
    logic [24:0] cv;
    bit          redo;
    bit          stored;
    stored = 1'b0;
    redo   = 1'b1;
    while (redo) begin
      redo = 1'b0;
      case (phase)
        LINE_START: begin
          if (b == CH_HASH) phase = SKIP_LINE;
          else if (b == CH_LF) phase = LINE_START;
          else if (is_blank(b)) phase = BEFORE_INDEX;
          else if (is_digit(b)) begin
            idx_acc = '0;
            idx_cnt = '0;
            phase   = IN_INDEX;
            redo    = 1'b1;
          end else halt(ERR_LINE);
        end
        SKIP_LINE: begin
          if (b == CH_LF) phase = LINE_START;
        end
        BEFORE_INDEX: begin
          if (is_digit(b)) begin
            idx_acc = '0;
            idx_cnt = '0;
            phase   = IN_INDEX;
            redo    = 1'b1;
          end else if (!is_blank(b)) halt(ERR_PRE_INDEX);
        end
        IN_INDEX: begin
          if (is_digit(b)) begin
            iv = int'(idx_acc) * 10 + int'(b - CH_ZERO);
            if (iv >= TABLE_ENTRIES) halt(ERR_OVERFLOW);
            else begin
              idx_acc = iv[8:0];
              if (idx_cnt != 2'd3) idx_cnt++;
            end
          end else if (idx_cnt == '0) halt(ERR_EMPTY_INDEX);
          else begin
            phase = BEFORE_CODE;
            redo  = 1'b1;
          end
        end
        BEFORE_CODE: begin
          if (b == CH_X) begin
            cp_acc = '0;
            cp_cnt = '0;
            phase  = IN_CODE;
          end else if (!is_blank(b) && b != CH_ZERO) halt(ERR_PRE_CODE);
        end
        IN_CODE: begin
          nib = hex_value(b);
          if (nib >= 0) begin
            cv = {cp_acc, 4'(nib)};
            if (cv > 25'(MAX_CODEPOINT)) halt(ERR_OVERFLOW);
            else begin
              cp_acc = cv[20:0];
              if (cp_cnt != 3'd7) cp_cnt++;
            end
          end else if (cp_cnt == '0) halt(ERR_EMPTY_CODE);
          else begin
            // A line feed right after the digits starts the next line at once.
            store_pair();
            stored = 1'b1;
            phase  = (b == CH_LF) ? LINE_START : SKIP_LINE;
          end
        end
        default: ;
      endcase
    end
    return stored;
  endfunction

  // Reply the block owes for one accepted command.
  function automatic reply_t predict_reply(input logic [1:0] op, input logic [7:0] text,
                                           input logic [7:0] qbyte, input logic [20:0] qcode);
    reply_t r;
    r.status = STAT_CONSUMED;
    r.err    = ERR_NONE;
    r.code   = '0;
    r.bval   = '0;
    r.hit    = 1'b0;
    case (op)
      CMD_PARSE: if (parse_text_byte(text)) r.status = STAT_STORED;
      CMD_FWD:   r.code = fwd_map[qbyte];
      CMD_REV: begin
        for (int i = 0; i < rev_fill; i++)
          if (!r.hit && rev_code[i] == qcode) begin
            r.bval = rev_byte[i];
            r.hit  = 1'b1;
          end
      end
      default: ;
    endcase
    if (phase == HALTED) begin
      r.status = STAT_ERROR;
      r.err    = latched_err;
    end
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Stimulus helpers: every field the command does not use carries random bits.
  task automatic push_cmd(input logic [1:0] op, input logic [7:0] text,
                          input logic [7:0] qbyte, input logic [20:0] qcode);
    feed_item_t it;
    it.pause_mark = 1'b0;
    it.op         = op;
    it.text       = text;
    it.qbyte      = qbyte;
    it.qcode      = qcode;
    text_feed.push_back(it);
  endtask

  task automatic push_pause();
    feed_item_t it;
    it.pause_mark = 1'b1;
    it.op         = CMD_PARSE;
    it.text       = '0;
    it.qbyte      = '0;
    it.qcode      = '0;
    text_feed.push_back(it);
  endtask

  task automatic push_text(input logic [7:0] b);
    push_cmd(CMD_PARSE, b, 8'($urandom), 21'($urandom));
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) push_text(s[i]);
  endtask

  task automatic push_fwd(input logic [7:0] qbyte);
    push_cmd(CMD_FWD, 8'($urandom), qbyte, 21'($urandom));
  endtask

  task automatic push_rev(input logic [20:0] qcode);
    push_cmd(CMD_REV, 8'($urandom), 8'($urandom), qcode);
  endtask

  // Any byte but a line feed, optionally also no hex digit.
  function automatic logic [7:0] filler_byte(input bit shun_hex);
    logic [7:0] b;
    do b = 8'($urandom);
    while (b == CH_LF || (shun_hex && hex_value(b) >= 0));
    return b;
  endfunction

  // One well-formed mapping line with random spelling: leading blanks, leading
  // zeros, a blank-and-zero separator, mixed-case hex and trailing junk.
  task automatic emit_mapping(input int idx, input logic [20:0] cp);
    logic [7:0] sep_chars [3];
    string      hex_txt;
    logic [7:0] b;
    sep_chars = '{CH_SPACE, CH_TAB, CH_ZERO};
    if ($urandom_range(99) < 15)
      repeat ($urandom_range(1, 2)) push_text($urandom_range(1) ? CH_SPACE : CH_TAB);
    if ($urandom_range(99) < 10) repeat ($urandom_range(1, 2)) push_text(CH_ZERO);
    push_str($sformatf("%0d", idx));
    // A zero straight after the index would count as an index digit, so a blank leads.
    if ($urandom_range(1)) begin
      push_text($urandom_range(1) ? CH_SPACE : CH_TAB);
      repeat ($urandom_range(0, 2)) push_text(sep_chars[$urandom_range(2)]);
    end
    push_text(CH_X);
    if ($urandom_range(99) < 10) repeat ($urandom_range(1, 2)) push_text(CH_ZERO);
    hex_txt = $sformatf("%0h", cp);
    for (int k = 0; k < hex_txt.len(); k++) begin
      b = hex_txt[k];
      if (b >= CH_LOWER_A && $urandom_range(1)) b = b - (CH_LOWER_A - CH_UPPER_A);
      push_text(b);
    end
    if ($urandom_range(99) < 75) push_text(CH_LF);
    else begin
      push_text(filler_byte(1'b1));
      repeat ($urandom_range(0, 3)) push_text(filler_byte(1'b0));
      push_text(CH_LF);
    end
  endtask

  // Driver: a new command goes out at the falling edge once the last one was
  // transferred; the offer holds steady until busy lets it through.
  always @(negedge clk_i) begin : feeder
    feed_item_t nxt;
    bit         offer;
    bit         may_idle;
    offer = 1'b0;
    // Transfers 500 to 899 go out back to back.
    may_idle = !(sent_count >= 500 && sent_count < 900);
    if (rst_ni && !(start && !xfer_now)) begin
      if (text_feed.size() != 0 && text_feed[0].pause_mark) begin
        if (replies_owed.size() == 0) void'(text_feed.pop_front());
      end else if (text_feed.size() != 0 && !(may_idle && $urandom_range(99) < 22)) begin
        nxt               = text_feed.pop_front();
        offer             = 1'b1;
        cmd_i             <= nxt.op;
        text_byte_i       <= nxt.text;
        query_byte_i      <= nxt.qbyte;
        query_codepoint_i <= nxt.qcode;
      end
      start <= offer;
    end
  end

  // Monitor: checks each strobed reply against the oldest owed one, then
  // predicts the reply for a command transferred at this edge.
  always @(posedge clk_i) begin : watcher
    reply_t want;
    xfer_now = 1'b0;
    if (rst_ni) begin
      if (done) begin
        if (replies_owed.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: reply with none expected: status %0d err %0d cp %0h byte %0h found %0b",
                     $time, parse_status_o, error_kind_o, codepoint_out_o, byte_out_o, found_o);
        end else begin
          want = replies_owed.pop_front();
          check_field("parse_status", want.status, parse_status_o);
          check_field("error_kind", want.err, error_kind_o);
          check_field("codepoint_out", want.code, codepoint_out_o);
          check_field("byte_out", want.bval, byte_out_o);
          check_field("found", want.hit, found_o);
        end
      end
      if (start && !busy) begin
        xfer_now = 1'b1;
        sent_count++;
        replies_owed.push_back(predict_reply(cmd_i, text_byte_i, query_byte_i, query_codepoint_i));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin : scenario
    bit          code_seen [int];
    logic [20:0] code_list [$];
    logic [20:0] cp;
    logic [7:0]  b;
    int          idx;
    int          pick;

    // Directed opening: unknown command, lookups on empty tables, a comment
    // holding an all-ones byte, an empty line, the largest index and codepoint,
    // and the smallest of both spelled with a tab, a blank and a zero.
    push_cmd(CMD_UNUSED, 8'hFF, 8'hFF, 21'h1FFFFF);
    push_rev(21'h1FFFFF);
    push_fwd(8'h00);
    push_text(CH_HASH);
    push_text(8'hFF);
    push_text(CH_LF);
    push_text(CH_LF);
    push_str("255x10FFFF");
    push_text(CH_LF);
    push_text(CH_TAB);
    push_str("0 0x0");
    push_text(CH_LF);
    push_fwd(8'hFF);
    push_rev(MAX_CODEPOINT);
    push_rev(21'h0);
    code_seen[0] = 1'b1;
    code_seen[int'(MAX_CODEPOINT)] = 1'b1;
    code_list.push_back(21'h0);
    code_list.push_back(MAX_CODEPOINT);
    push_pause();

    // Random body: mostly mapping lines, with comments, empty lines and lookups
    // mixed in. After the first few hundred commands, a run of short lines with
    // fresh three-digit codepoints pushes the reverse list past its end.
    while (text_feed.size() < 1900 || code_seen.num() < 272) begin
      if (text_feed.size() >= 400 && code_seen.num() < 272) begin
        do cp = 21'($urandom_range('h100, 'hFFF));
        while (code_seen.exists(int'(cp)));
        code_seen[int'(cp)] = 1'b1;
        code_list.push_back(cp);
        push_str($sformatf("%0dx%0h", $urandom_range(9), cp));
        push_text(CH_LF);
      end else begin
        pick = $urandom_range(99);
        if (pick < 12) push_fwd(8'($urandom));
        else if (pick < 20) begin
          case ($urandom_range(9))
            0, 1:    push_rev(21'($urandom));
            2, 3, 4: push_rev(21'($urandom_range(0, MAX_CODEPOINT)));
            default: push_rev(code_list[$urandom_range(code_list.size() - 1)]);
          endcase
        end else if (pick < 22) push_cmd(CMD_UNUSED, 8'($urandom), 8'($urandom), 21'($urandom));
        else if (pick < 28) begin
          push_text(CH_HASH);
          repeat ($urandom_range(0, 3)) push_text(filler_byte(1'b0));
          push_text(CH_LF);
        end else if (pick < 32) push_text(CH_LF);
        else begin
          pick = $urandom_range(9);
          idx  = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(255);
          pick = $urandom_range(99);
          if (pick < 15) cp = code_list[$urandom_range(code_list.size() - 1)];
          else if (pick < 20) cp = MAX_CODEPOINT;
          else if (pick < 24) cp = '0;
          else if (pick < 70) cp = 21'($urandom_range(0, 'hFFF));
          else cp = 21'($urandom_range(0, MAX_CODEPOINT));
          if (!code_seen.exists(int'(cp))) begin
            code_seen[int'(cp)] = 1'b1;
            code_list.push_back(cp);
          end
          emit_mapping(idx, cp);
        end
      end
    end

    // Broken tail: one error kind per run, picked at random, then more traffic
    // that must all report the latched error. An empty index cannot arise,
    // since the index field is only entered on a digit.
    push_pause();
    case ($urandom_range(4))
      0: begin
        do b = 8'($urandom);
        while (b == CH_HASH || b == CH_LF || is_blank(b) || is_digit(b));
        push_text(b);
      end
      1: push_str(" k");
      2: push_str("12 k");
      3: push_str("12xk");
      default: begin
        if ($urandom_range(1)) push_str("256");
        else push_str("1x110000");
      end
    endcase
    repeat (20) push_cmd(2'($urandom), 8'($urandom), 8'($urandom), 21'($urandom));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (text_feed.size() != 0 || start || replies_owed.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end

endmodule
